// ----- hw/rtl/fen_rec_pkg.sv -----
package fen_rec_pkg;

  // count parser phase
  typedef enum logic [1:0] {
    PH_LEAD  = 2'd0,
    PH_SIGN  = 2'd1,
    PH_DIGIT = 2'd2
  } num_phase_t;

  // field indexes within a record
  localparam logic [2:0] FLD_PLACE  = 3'd0;
  localparam logic [2:0] FLD_SIDE   = 3'd1;
  localparam logic [2:0] FLD_CASTLE = 3'd2;
  localparam logic [2:0] FLD_EP     = 3'd3;
  localparam logic [2:0] FLD_HALF   = 3'd4;
  localparam logic [2:0] FLD_FULL   = 3'd5;

  // character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_3     = 8'h33;
  localparam logic [7:0] CH_6     = 8'h36;
  localparam logic [7:0] CH_8     = 8'h38;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_K_UP  = 8'h4B;
  localparam logic [7:0] CH_Q_UP  = 8'h51;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_B_LO  = 8'h62;
  localparam logic [7:0] CH_H_LO  = 8'h68;
  localparam logic [7:0] CH_K_LO  = 8'h6B;
  localparam logic [7:0] CH_Q_LO  = 8'h71;
  localparam logic [7:0] CH_W_LO  = 8'h77;

  // board geometry
  localparam logic [3:0] SQ_PER_RANK = 4'd8;
  localparam logic [3:0] RANK_COUNT  = 4'd8;

  // count parser status toward the field checker
  typedef struct packed {
    logic char_bad;      // current byte is illegal at this point of the count
    logic cur_half_bad;  // halfmove check on the present state
    logic cur_full_bad;  // fullmove check on the present state
    logic nxt_half_bad;  // halfmove check after taking the current byte
    logic nxt_full_bad;  // fullmove check after taking the current byte
  } num_stat_t;

endpackage

// ----- hw/rtl/fen_rec_count.sv -----
module fen_rec_count import fen_rec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       num_en,
  input  logic       num_clr,
  input  logic [7:0] char_code,
  output num_stat_t  stat
);

  num_phase_t  phase_r, phase_nxt;
  logic        neg_r, neg_nxt;
  logic [30:0] mag_r, mag_nxt;
  logic        ovf_r, ovf_nxt;
  logic        is_digit;
  logic [34:0] prod;

  function automatic logic half_bad(num_phase_t ph, logic ovf, logic neg, logic [30:0] mag);
    return (ph != PH_DIGIT) || ovf || (neg && (mag != '0));
  endfunction

  function automatic logic full_bad(num_phase_t ph, logic ovf, logic neg, logic [30:0] mag);
    return (ph != PH_DIGIT) || ovf || neg || (mag == '0);
  endfunction

  // magnitude * 10 + digit, as two shifts and two adds
  assign is_digit = (char_code >= CH_0) && (char_code <= CH_9);
  assign prod = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + {31'b0, char_code[3:0]};

  // stoi-like parse: whitespace, sign, digits
  always_comb begin
    phase_nxt     = phase_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    ovf_nxt       = ovf_r;
    stat.char_bad = 1'b0;
    if (phase_r == PH_LEAD && (char_code inside {[CH_TAB:CH_CR]})) begin
      phase_nxt = phase_r;
    end else if (phase_r == PH_LEAD && (char_code == CH_PLUS || char_code == CH_DASH)) begin
      neg_nxt   = (char_code == CH_DASH);
      phase_nxt = PH_SIGN;
    end else if (!is_digit) begin
      stat.char_bad = 1'b1;
    end else begin
      phase_nxt = PH_DIGIT;
      if (!ovf_r) begin
        if (prod[34:31] != 4'd0) begin
          ovf_nxt = 1'b1;
        end else begin
          mag_nxt = prod[30:0];
        end
      end
    end
    stat.cur_half_bad = half_bad(phase_r, ovf_r, neg_r, mag_r);
    stat.cur_full_bad = full_bad(phase_r, ovf_r, neg_r, mag_r);
    stat.nxt_half_bad = half_bad(phase_nxt, ovf_nxt, neg_nxt, mag_nxt);
    stat.nxt_full_bad = full_bad(phase_nxt, ovf_nxt, neg_nxt, mag_nxt);
  end

  // parser state; cleared at each field boundary
  always_ff @(posedge clk) begin
    if (!rst_n || num_clr) begin
      phase_r <= PH_LEAD;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      ovf_r   <= 1'b0;
    end else if (num_en) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

endmodule

// ----- hw/rtl/fen_rec_fsm.sv -----
module fen_rec_fsm import fen_rec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_code,
  input  logic       final_char,
  output logic       verdict
);

  logic [2:0] field_number_r;
  logic [1:0] chars_in_field_r, cif_fc;
  logic [7:0] field_first_char_r, ffc_fc;
  logic [3:0] rank_number_r, rank_fc;
  logic [3:0] squares_in_rank_r, sq_fc;
  logic [3:0] rights_seen_r, rights_fc;
  logic       record_failed_r, failed_nxt;

  logic       is_space, active, num_en, num_clr;
  logic       char_fail, is_piece, is_num18;
  logic [3:0] add, bit_sel;
  logic [4:0] sum;
  num_stat_t  nstat;

  function automatic logic end_bad(logic [2:0] fn, logic [1:0] cif, logic [7:0] ffc,
                                   logic [3:0] rank, logic [3:0] sq,
                                   logic hbad, logic fbad);
    logic bad;
    case (fn)
      FLD_PLACE: begin
        // a trailing slash already closed the last rank
        if (cif != 2'd0 && sq == 4'd0) bad = (rank != RANK_COUNT);
        else bad = (sq != SQ_PER_RANK) || (rank != RANK_COUNT - 4'd1);
      end
      FLD_SIDE:   bad = (cif != 2'd1) || (ffc != CH_W_LO && ffc != CH_B_LO);
      FLD_CASTLE: bad = 1'b0;
      FLD_EP:     bad = (cif == 2'd1) ? (ffc != CH_DASH) : (cif != 2'd2);
      FLD_HALF:   bad = hbad;
      default:    bad = fbad;
    endcase
    return bad;
  endfunction

  fen_rec_count u_count (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_en    (num_en),
    .num_clr   (num_clr),
    .char_code (char_code),
    .stat      (nstat)
  );

  assign is_space = (char_code == CH_SPACE);
  assign active   = step && !record_failed_r;
  assign num_en   = active && !is_space && (field_number_r >= FLD_HALF);
  assign num_clr  = step && (final_char || (!record_failed_r && is_space));

  // per-character field checks
  always_comb begin
    cif_fc    = (chars_in_field_r == 2'd3) ? 2'd3 : chars_in_field_r + 2'd1;
    ffc_fc    = (chars_in_field_r == 2'd0) ? char_code : field_first_char_r;
    rank_fc   = rank_number_r;
    sq_fc     = squares_in_rank_r;
    rights_fc = rights_seen_r;
    char_fail = 1'b0;
    is_piece  = char_code inside {8'h70, 8'h6E, 8'h62, 8'h72, 8'h71, 8'h6B,
                                  8'h50, 8'h4E, 8'h42, 8'h52, 8'h51, 8'h4B};
    is_num18  = (char_code >= CH_1) && (char_code <= CH_8);
    add       = is_num18 ? char_code[3:0] : 4'd1;
    sum       = {1'b0, squares_in_rank_r} + {1'b0, add};
    bit_sel   = 4'd0;
    case (field_number_r)
      FLD_PLACE: begin
        if (char_code == CH_SLASH) begin
          if (squares_in_rank_r != SQ_PER_RANK || rank_number_r >= RANK_COUNT) begin
            char_fail = 1'b1;
          end else begin
            rank_fc = rank_number_r + 4'd1;
          end
          sq_fc = 4'd0;
        end else if (!is_num18 && !is_piece) begin
          char_fail = 1'b1;
        end else if (sum > {1'b0, SQ_PER_RANK}) begin
          char_fail = 1'b1;
        end else begin
          sq_fc = sum[3:0];
        end
      end
      FLD_SIDE: begin
        char_fail = 1'b0;
      end
      FLD_CASTLE: begin
        if (char_code == CH_DASH) begin
          char_fail = (chars_in_field_r != 2'd0);
        end else begin
          case (char_code)
            CH_K_UP: bit_sel = 4'b0001;
            CH_Q_UP: bit_sel = 4'b0010;
            CH_K_LO: bit_sel = 4'b0100;
            CH_Q_LO: bit_sel = 4'b1000;
            default: bit_sel = 4'b0000;
          endcase
          if (bit_sel == 4'd0 || (rights_seen_r & bit_sel) != 4'd0 ||
              (chars_in_field_r != 2'd0 && field_first_char_r == CH_DASH)) begin
            char_fail = 1'b1;
          end else begin
            rights_fc = rights_seen_r | bit_sel;
          end
        end
      end
      FLD_EP: begin
        if (chars_in_field_r == 2'd1) begin
          char_fail = (field_first_char_r < CH_A_LO) || (field_first_char_r > CH_H_LO) ||
                      (char_code != CH_3 && char_code != CH_6);
        end else if (chars_in_field_r >= 2'd2) begin
          char_fail = 1'b1;
        end
      end
      default: char_fail = nstat.char_bad;
    endcase
  end

  // record verdict after this byte
  always_comb begin
    failed_nxt = record_failed_r;
    if (active) begin
      if (is_space) begin
        failed_nxt = end_bad(field_number_r, chars_in_field_r, field_first_char_r,
                             rank_number_r, squares_in_rank_r,
                             nstat.cur_half_bad, nstat.cur_full_bad) |
                     ((field_number_r >= FLD_FULL) ? !final_char : final_char);
      end else begin
        failed_nxt = char_fail |
                     (final_char & (end_bad(field_number_r, cif_fc, ffc_fc, rank_fc, sq_fc,
                                            nstat.nxt_half_bad, nstat.nxt_full_bad) |
                                    (field_number_r != FLD_FULL)));
      end
    end
    verdict = !failed_nxt;
  end

  // field state; everything clears after the final byte
  always_ff @(posedge clk) begin
    if (!rst_n || (step && final_char)) begin
      field_number_r     <= FLD_PLACE;
      chars_in_field_r   <= 2'd0;
      field_first_char_r <= 8'd0;
      rank_number_r      <= 4'd0;
      squares_in_rank_r  <= 4'd0;
      rights_seen_r      <= 4'd0;
      record_failed_r    <= 1'b0;
    end else if (active) begin
      record_failed_r <= failed_nxt;
      if (is_space) begin
        if (field_number_r < FLD_FULL) field_number_r <= field_number_r + 3'd1;
        chars_in_field_r   <= 2'd0;
        field_first_char_r <= 8'd0;
        rank_number_r      <= 4'd0;
        squares_in_rank_r  <= 4'd0;
        rights_seen_r      <= 4'd0;
      end else begin
        chars_in_field_r   <= cif_fc;
        field_first_char_r <= ffc_fc;
        rank_number_r      <= rank_fc;
        squares_in_rank_r  <= sq_fc;
        rights_seen_r      <= rights_fc;
      end
    end
  end

endmodule

// ----- hw/rtl/fen_record_validator.sv -----
// FEN record validator: takes one byte of chess position text per cycle while
// in_ready is high and, on the byte flagged by in_final_char, returns one result
// saying whether the whole record was a valid FEN (six fields, eight ranks of
// eight squares, side, castling, en passant, halfmove >= 0, fullmove >= 1). Bytes
// that are not final give no result. The final byte passes from the input
// register through the combinational field checker, whose verdict loads the
// result register. A waiting verdict only stalls the next final byte, not
// ordinary bytes.
module fen_record_validator import fen_rec_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_code,
  input  logic       in_final_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_record_valid
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_final_r;
  logic       out_valid_r;
  logic       out_record_valid_r;
  logic       proc;
  logic       verdict;

  // a byte moves on unless it is final and the result slot is still full
  assign proc     = s1_valid_r && (!s1_final_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || proc;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r  <= in_char_code;
      s1_final_r <= in_final_char;
    end
  end

  fen_rec_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (proc),
    .char_code  (s1_char_r),
    .final_char (s1_final_r),
    .verdict    (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && s1_final_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_final_r) begin
      out_record_valid_r <= verdict;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_record_valid = out_record_valid_r;

endmodule
